[rtl/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg: shared definitions for the fit-policy block allocator
// Field widths, status and policy codes, controller/datapath interface types
// and the saturating counter helper.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int DefTableDepth = 64;
  localparam int DefSizeBits   = 16;

  localparam int SizeFieldW = 16;
  localparam int IdxFieldW  = 6;
  localparam int CountW     = 32;
  localparam int FreeW      = 22;
  localparam int PolicyW    = 2;
  localparam int StatusW    = 3;

  localparam int InDataW  = SizeFieldW;
  localparam int InUserW  = 1;
  localparam int OutUserW = StatusW;
  localparam int OutDataW = 128;

  localparam logic [FreeW-1:0] FreeMax = '1;

  typedef enum logic [StatusW-1:0] {
    STATUS_LOADED  = 3'd0,
    STATUS_GRANTED = 3'd1,
    STATUS_NOGRANT = 3'd2,
    STATUS_SKIPPED = 3'd3,
    STATUS_FULL    = 3'd4
  } status_e;

  localparam logic [PolicyW-1:0] POLICY_FIRST = 2'd0;
  localparam logic [PolicyW-1:0] POLICY_BEST  = 2'd1;
  localparam logic [PolicyW-1:0] POLICY_WORST = 2'd2;

  localparam logic CMD_APPEND  = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Commands from the controller to the datapath, one step per cycle.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_req;
    logic scan_hit;
    logic scan_done;
  } dp_stat_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/fpba_ctrl.sv]
// ----------------------------------------------------------------------------
// fpba_ctrl: sequencer of the fit-policy block allocator
// Takes one item at a time, steps the datapath through execute and, for a
// nonzero request, table scan and write back, and loads the output register.
// ----------------------------------------------------------------------------
module fpba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output logic              out_load_o,
  output fpba_pkg::dp_cmd_t cmd_o,
  input  fpba_pkg::dp_stat_t stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i && ready_q;
        if (in_valid_i && ready_q) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.scan_req ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_hit || stat_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // Wait here only while the previous result has not been taken.
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

[rtl/fpba_dp.sv]
// ----------------------------------------------------------------------------
// fpba_dp: datapath of the fit-policy block allocator
// Holds the block table memory, the policy register, the scan pointer and
// candidate registers, and the saturating running totals.
// ----------------------------------------------------------------------------
module fpba_dp #(
  parameter int TABLE_DEPTH = fpba_pkg::DefTableDepth,
  parameter int SIZE_BITS   = fpba_pkg::DefSizeBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fpba_pkg::dp_cmd_t              cmd_i,
  output fpba_pkg::dp_stat_t             stat_o,
  input  logic                           cfg_valid_i,
  input  logic [fpba_pkg::PolicyW-1:0]   cfg_data_i,
  input  logic                           in_command_i,
  input  logic [fpba_pkg::SizeFieldW-1:0] in_size_i,
  output fpba_pkg::status_e              res_status_o,
  output logic [fpba_pkg::IdxFieldW-1:0] res_index_o,
  output logic [fpba_pkg::CountW-1:0]    visits_o,
  output logic [fpba_pkg::CountW-1:0]    failures_o,
  output logic [fpba_pkg::CountW-1:0]    requests_o,
  output logic [fpba_pkg::FreeW-1:0]     free_o
);

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int InW   = (SIZE_BITS < fpba_pkg::SizeFieldW) ? SIZE_BITS
                                                            : fpba_pkg::SizeFieldW;
  localparam int EntW  = SIZE_BITS + 1;

  // Each word is {valid, size}. Only words below the fill count are read.
  logic [EntW-1:0] mem_q [TABLE_DEPTH];

  logic [fpba_pkg::PolicyW-1:0] policy_q;
  logic                         cmd_q;
  logic [SIZE_BITS-1:0]         req_q;
  logic [CntW-1:0]              count_q;
  logic [CntW-1:0]              rd_addr_q;
  logic                         rd_vld_q;
  logic [EntW-1:0]              rd_data_q;
  logic [AddrW-1:0]             rd_idx_q;
  logic                         pick_vld_q;
  logic [AddrW-1:0]             pick_idx_q;
  logic [SIZE_BITS-1:0]         pick_slack_q;
  logic [fpba_pkg::CountW-1:0]  visits_q;
  logic [fpba_pkg::CountW-1:0]  fails_q;
  logic [fpba_pkg::CountW-1:0]  reqs_q;
  logic [fpba_pkg::FreeW-1:0]   free_q;
  fpba_pkg::status_e            res_status_q;
  logic [fpba_pkg::IdxFieldW-1:0] res_idx_q;

  logic                       table_full;
  logic                       req_zero;
  logic                       rd_issue;
  logic [SIZE_BITS-1:0]       ent_size;
  logic                       ent_valid;
  logic                       visit;
  logic [SIZE_BITS-1:0]       slack;
  logic                       fits;
  logic                       exact;
  logic                       hit;
  logic                       take;
  logic [fpba_pkg::FreeW:0]   free_add;
  logic [fpba_pkg::FreeW-1:0] free_sub;

  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign req_zero   = (req_q == '0);
  assign rd_issue   = (rd_addr_q < count_q);
  assign ent_size   = rd_data_q[SIZE_BITS-1:0];
  assign ent_valid  = rd_data_q[SIZE_BITS];
  assign visit      = cmd_i.scan && rd_vld_q && ent_valid;
  assign slack      = ent_size - req_q;
  assign fits       = (ent_size >= req_q);
  assign exact      = (ent_size == req_q);

  // Best fit keeps the first of equal slacks; worst fit moves to the last.
  always_comb begin
    hit  = 1'b0;
    take = 1'b0;
    case (policy_q)
      fpba_pkg::POLICY_BEST: begin
        if (exact) begin
          hit = 1'b1;
        end else if (!exact && fits && (!pick_vld_q || slack < pick_slack_q)) begin
          take = 1'b1;
        end
      end
      fpba_pkg::POLICY_WORST: begin
        if (fits && (!pick_vld_q || slack >= pick_slack_q)) begin
          take = 1'b1;
        end
      end
      default: begin
        hit = fits;
      end
    endcase
  end

  assign free_add = {1'b0, free_q} + (fpba_pkg::FreeW + 1)'(req_q);
  assign free_sub = (free_q > fpba_pkg::FreeW'(req_q))
                    ? free_q - fpba_pkg::FreeW'(req_q) : '0;

  assign stat_o.scan_req  = (cmd_q == fpba_pkg::CMD_REQUEST) && !req_zero;
  assign stat_o.scan_hit  = visit && hit;
  assign stat_o.scan_done = !rd_vld_q && !rd_issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= fpba_pkg::POLICY_FIRST;
      count_q    <= '0;
      rd_addr_q  <= '0;
      rd_vld_q   <= 1'b0;
      pick_vld_q <= 1'b0;
      visits_q   <= '0;
      fails_q    <= '0;
      reqs_q     <= '0;
      free_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        policy_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        if (cmd_q == fpba_pkg::CMD_APPEND) begin
          if (!table_full) begin
            count_q <= count_q + 1'b1;
            free_q  <= free_add[fpba_pkg::FreeW] ? fpba_pkg::FreeMax
                                                 : free_add[fpba_pkg::FreeW-1:0];
          end
        end else begin
          reqs_q     <= fpba_pkg::sat_inc(reqs_q);
          rd_addr_q  <= '0;
          rd_vld_q   <= 1'b0;
          pick_vld_q <= 1'b0;
        end
      end
      if (cmd_i.scan) begin
        rd_vld_q <= rd_issue;
        if (rd_issue) begin
          rd_addr_q <= rd_addr_q + 1'b1;
        end
        if (visit) begin
          visits_q <= fpba_pkg::sat_inc(visits_q);
          if (hit || take) begin
            pick_vld_q <= 1'b1;
          end
        end
      end
      if (cmd_i.commit) begin
        if (pick_vld_q) begin
          free_q <= free_sub;
        end else begin
          fails_q <= fpba_pkg::sat_inc(fails_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_command_i;
      req_q <= SIZE_BITS'(in_size_i[InW-1:0]);
    end
    if (cmd_i.exec) begin
      if (cmd_q == fpba_pkg::CMD_APPEND) begin
        if (table_full) begin
          res_status_q <= fpba_pkg::STATUS_FULL;
          res_idx_q    <= '0;
        end else begin
          mem_q[count_q[AddrW-1:0]] <= {1'b1, req_q};
          res_status_q <= fpba_pkg::STATUS_LOADED;
          res_idx_q    <= fpba_pkg::IdxFieldW'(count_q[AddrW-1:0]);
        end
      end else begin
        // A scanned request overwrites this at write back.
        res_status_q <= fpba_pkg::STATUS_SKIPPED;
        res_idx_q    <= '0;
      end
    end
    if (cmd_i.scan) begin
      if (rd_issue) begin
        rd_data_q <= mem_q[rd_addr_q[AddrW-1:0]];
        rd_idx_q  <= rd_addr_q[AddrW-1:0];
      end
      if (visit && (hit || take)) begin
        pick_idx_q   <= rd_idx_q;
        pick_slack_q <= slack;
      end
    end
    if (cmd_i.commit) begin
      if (pick_vld_q) begin
        mem_q[pick_idx_q] <= {(pick_slack_q != '0), pick_slack_q};
        res_status_q      <= fpba_pkg::STATUS_GRANTED;
        res_idx_q         <= fpba_pkg::IdxFieldW'(pick_idx_q);
      end else begin
        res_status_q <= fpba_pkg::STATUS_NOGRANT;
        res_idx_q    <= '0;
      end
    end
  end

  assign res_status_o = res_status_q;
  assign res_index_o  = res_idx_q;
  assign visits_o     = visits_q;
  assign failures_o   = fails_q;
  assign requests_o   = reqs_q;
  assign free_o       = free_q;

endmodule

[rtl/fit_policy_block_allocator.sv]
// Sequence: an append or a zero-size request has its result registered in the
// execute step; any other request scans the filled entries in order, stopping
// at a match where the policy allows, and then writes the result back.
// Flow: one item at a time; the next transfer is taken only after the result
// is moved to the output register, and a result not yet taken holds off the next one.
// Reset: asynchronous, clears the table fill count, totals and policy.
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: first/best/worst fit block allocator
// Loads a table of free block sizes and serves size requests by a scan of
// the table under the configured fit policy, with saturating totals.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
  parameter int TABLE_DEPTH = fpba_pkg::DefTableDepth,
  parameter int SIZE_BITS   = fpba_pkg::DefSizeBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fpba_pkg::PolicyW-1:0]   cfg_data_i,   // fit_policy
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fpba_pkg::InDataW-1:0]   s_axis_tdata,  // size_value
  input  logic [fpba_pkg::InUserW-1:0]   s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // block_index, visits_total, failures_total, requests_total, free_total
  output logic [fpba_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [fpba_pkg::OutUserW-1:0]  m_axis_tuser   // status
);

  localparam int PadW = fpba_pkg::OutDataW
                        - (fpba_pkg::IdxFieldW + 3 * fpba_pkg::CountW + fpba_pkg::FreeW);

  fpba_pkg::dp_cmd_t              dp_cmd;
  fpba_pkg::dp_stat_t             dp_stat;
  fpba_pkg::status_e              res_status;
  logic [fpba_pkg::IdxFieldW-1:0] res_index;
  logic [fpba_pkg::CountW-1:0]    visits;
  logic [fpba_pkg::CountW-1:0]    failures;
  logic [fpba_pkg::CountW-1:0]    requests;
  logic [fpba_pkg::FreeW-1:0]     free_sum;
  logic                           out_free;
  logic                           out_load;

  logic                          out_vld_q;
  logic [fpba_pkg::OutDataW-1:0] out_data_q;
  logic [fpba_pkg::OutUserW-1:0] out_user_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || m_axis_tready;

  fpba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .cmd_o      (dp_cmd),
    .stat_i     (dp_stat)
  );

  fpba_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SIZE_BITS   (SIZE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_command_i (s_axis_tuser[0]),
    .in_size_i    (s_axis_tdata),
    .res_status_o (res_status),
    .res_index_o  (res_index),
    .visits_o     (visits),
    .failures_o   (failures),
    .requests_o   (requests),
    .free_o       (free_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // The totals are captured here so later items cannot disturb a held result.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_user_q <= res_status;
      out_data_q <= {{PadW{1'b0}}, free_sum, requests, failures, visits, res_index};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[rtl/fpba_checker.sv]
// ----------------------------------------------------------------------------
// fpba_checker: port-level checks for the fit-policy block allocator
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module fpba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fpba_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [fpba_pkg::OutUserW-1:0] m_axis_tuser
);

  // A result that is not taken holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("held result changed before transfer");

  // One item at a time: no input transfer right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  // Only loads and grants name a table entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != fpba_pkg::STATUS_LOADED
      && m_axis_tuser != fpba_pkg::STATUS_GRANTED |-> m_axis_tdata[5:0] == '0)
    else $error("entry index nonzero without load or grant");

  // A refused request has been counted as a failure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == fpba_pkg::STATUS_NOGRANT
      |-> m_axis_tdata[69:38] != '0)
    else $error("refusal without failure count");

  // Any request outcome has been counted as a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fpba_pkg::STATUS_GRANTED
      || m_axis_tuser == fpba_pkg::STATUS_NOGRANT
      || m_axis_tuser == fpba_pkg::STATUS_SKIPPED) |-> m_axis_tdata[101:70] != '0)
    else $error("request outcome without request count");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[test/fit_policy_block_allocator_tb.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb: self-checking bench for the block allocator
// Drives table appends and size requests under first, best, worst and the
// spare fit code, predicts every result with a behavioral copy of the table
// and compares each output transfer field by field, with random idle gaps on
// the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  localparam int          TableDepth   = DefTableDepth;
  localparam int          PhaseItems   = 230;
  localparam int          NumPhases    = 7;
  localparam int          NumPlanRows  = 26;
  localparam int unsigned CycleLimit   = 4000000;
  localparam int          ReportLimit  = 10;
  localparam logic [PolicyW-1:0] POLICY_SPARE = 2'd3;

  typedef struct packed {
    status_e               status;
    logic [IdxFieldW-1:0]  index;
    logic [CountW-1:0]     visits;
    logic [CountW-1:0]     failures;
    logic [CountW-1:0]     requests;
    logic [FreeW-1:0]      free;
  } alloc_result_t;

  // One line of the directed plan: either a policy write or an item, with
  // status and index spelled out where they are obvious.
  typedef struct packed {
    logic                  is_cfg;
    logic [PolicyW-1:0]    policy;
    logic                  cmd;
    logic [SizeFieldW-1:0] size;
    logic                  typed;
    status_e               status;
    logic [IdxFieldW-1:0]  index;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [PolicyW-1:0]   cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;  // size_value
  logic [InUserW-1:0]   s_axis_tuser = '0;  // command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // block_index, visits_total, failures_total, requests_total, free_total
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [OutUserW-1:0]  m_axis_tuser;       // status

  // Shadow copy of the allocator state.
  logic [SizeFieldW-1:0] tbl_size [TableDepth];
  logic                  tbl_live [TableDepth];
  int unsigned           fill_count = 0;
  logic [CountW-1:0]     visit_count = '0;
  logic [CountW-1:0]     fail_count = '0;
  logic [CountW-1:0]     req_count = '0;
  logic [FreeW-1:0]      free_sum = '0;
  logic [PolicyW-1:0]    fit_sel = POLICY_FIRST;

  alloc_result_t pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned sink_stall = 0;
  int unsigned sink_calm = 0;
  int unsigned status_seen [5] = '{default: 0};
  int unsigned items_sent = 0;
  int unsigned policy_writes = 0;

  plan_row_t plan [NumPlanRows] = '{
    // is_cfg, policy, cmd, size, typed, status, index
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd0,     1'b1, STATUS_SKIPPED, 6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd5,     1'b1, STATUS_NOGRANT, 6'd0},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'd0,     1'b1, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'hFFFF,  1'b1, STATUS_LOADED,  6'd1},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'd100,   1'b1, STATUS_LOADED,  6'd2},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'd100,   1'b1, STATUS_LOADED,  6'd3},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'd300,   1'b1, STATUS_LOADED,  6'd4},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'd1,     1'b1, STATUS_LOADED,  6'd5},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd1,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'hFFFF,  1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd100,   1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'h8000,  1'b0, STATUS_LOADED,  6'd0},
    '{1'b1, POLICY_BEST,  CMD_APPEND,  16'd0,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd100,   1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd250,   1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd1,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b1, POLICY_WORST, CMD_APPEND,  16'd0,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd1,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'hFFFF,  1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_APPEND,  16'hFFFF,  1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'hFFFF,  1'b0, STATUS_LOADED,  6'd0},
    '{1'b1, POLICY_SPARE, CMD_APPEND,  16'd0,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd1,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'hFFFF,  1'b0, STATUS_LOADED,  6'd0},
    '{1'b1, POLICY_FIRST, CMD_APPEND,  16'd0,     1'b0, STATUS_LOADED,  6'd0},
    '{1'b0, POLICY_FIRST, CMD_REQUEST, 16'd0,     1'b0, STATUS_LOADED,  6'd0}
  };

  logic [PolicyW-1:0] phase_policy [NumPhases] = '{
    POLICY_BEST, POLICY_WORST, POLICY_SPARE, POLICY_FIRST,
    POLICY_WORST, POLICY_BEST, POLICY_FIRST
  };

  fit_policy_block_allocator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [CountW-1:0] bump_sat(input logic [CountW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  // of back-to-back cycles.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) calm = $urandom_range(60, 20);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 20);
  endfunction

  // Applies one item to the shadow table and returns the result it causes.
  function automatic alloc_result_t predict_allocation(input logic cmd,
                                                       input logic [SizeFieldW-1:0] size);
    alloc_result_t         res;
    int                    pick;
    int unsigned           i;
    logic [SizeFieldW-1:0] sz;
    logic [SizeFieldW-1:0] slack_best;
    logic [FreeW:0]        grown;
    res.index  = '0;
    pick       = -1;
    slack_best = '0;
    if (cmd == CMD_APPEND) begin
      if (fill_count >= TableDepth) begin
        res.status = STATUS_FULL;
      end else begin
        res.index = IdxFieldW'(fill_count);
        tbl_size[fill_count] = size;
        tbl_live[fill_count] = 1'b1;
        fill_count++;
        grown = free_sum + size;
        free_sum = (grown > FreeMax) ? FreeMax : grown[FreeW-1:0];
        res.status = STATUS_LOADED;
      end
    end else begin
      req_count = bump_sat(req_count);
      if (size == '0) begin
        res.status = STATUS_SKIPPED;
      end else begin
        for (i = 0; i < fill_count; i++) begin
          if (!tbl_live[i]) continue;
          visit_count = bump_sat(visit_count);
          sz = tbl_size[i];
          if (fit_sel == POLICY_BEST) begin
            if (sz == size) begin
              pick = i;
              break;
            end
            if (sz > size && (pick < 0 || sz - size < slack_best)) begin
              pick = i;
              slack_best = sz - size;
            end
          end else if (fit_sel == POLICY_WORST) begin
            // Ties move the choice toward the end of the table.
            if (sz >= size && (pick < 0 || sz - size >= slack_best)) begin
              pick = i;
              slack_best = sz - size;
            end
          end else if (sz >= size) begin
            pick = i;
            break;
          end
        end
        if (pick < 0) begin
          fail_count = bump_sat(fail_count);
          res.status = STATUS_NOGRANT;
        end else begin
          res.index = IdxFieldW'(pick);
          tbl_size[pick] = tbl_size[pick] - size;
          if (tbl_size[pick] == '0) tbl_live[pick] = 1'b0;
          free_sum = (free_sum > size) ? free_sum - size : '0;
          res.status = STATUS_GRANTED;
        end
      end
    end
    res.visits   = visit_count;
    res.failures = fail_count;
    res.requests = req_count;
    res.free     = free_sum;
    return res;
  endfunction

  // Random traffic is mostly requests that the table can serve, with a thin
  // stream of appends that brings fresh blocks, thinner once the table is full.
  task automatic random_item(output logic cmd, output logic [SizeFieldW-1:0] size);
    int unsigned r;
    int unsigned s;
    int unsigned live_idx [$];
    r = $urandom_range(99);
    s = $urandom_range(99);
    if ((fill_count < TableDepth && r < 5) || r < 2) begin
      cmd = CMD_APPEND;
      if (s < 10) size = '0;
      else if (s < 20) size = '1;
      else if (s < 35 && fill_count > 0) size = tbl_size[$urandom_range(fill_count - 1)];
      else size = $urandom_range(16'hFFFF, 1);
    end else begin
      cmd = CMD_REQUEST;
      if (s < 10) begin
        size = '0;
      end else if (s < 13) begin
        // Exact size of a live block, so best fit finds a match and the
        // block is used up.
        for (int unsigned k = 0; k < fill_count; k++)
          if (tbl_live[k] && tbl_size[k] != '0) live_idx.push_back(k);
        size = (live_idx.size() > 0) ?
               tbl_size[live_idx[$urandom_range(live_idx.size() - 1)]] : 16'd1;
      end else if (s < 15) begin
        size = $urandom_range(16'hFFFF, 1);
      end else if (s < 40) begin
        size = $urandom_range(4095, 1);
      end else begin
        size = $urandom_range(255, 1);
      end
    end
  endtask

  // Offers one item; valid stays high only when another item follows at once.
  task automatic send_item(input logic cmd, input logic [SizeFieldW-1:0] size,
                           input bit more, input plan_row_t row);
    alloc_result_t exp;
    repeat (send_gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= size;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    exp = predict_allocation(cmd, size);
    if (row.typed) begin
      exp.status = row.status;
      exp.index  = row.index;
    end
    pending_results.push_back(exp);
    status_seen[exp.status]++;
    items_sent++;
    send_gap = pick_gap(send_calm);
    if (send_gap != 0 || !more) s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_policy(input logic [PolicyW-1:0] policy);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= policy;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fit_sel = policy;
    policy_writes++;
    send_gap = 0;
  endtask

  // Output side: compare each transfer, then pick the next stall.
  always @(posedge clk_i) begin
    alloc_result_t exp;
    alloc_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status   = status_e'(m_axis_tuser);
      got.index    = m_axis_tdata[5:0];
      got.visits   = m_axis_tdata[37:6];
      got.failures = m_axis_tdata[69:38];
      got.requests = m_axis_tdata[101:70];
      got.free     = m_axis_tdata[123:102];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected result: status %0d index %0d", got.status, got.index);
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.index !== exp.index ||
            got.visits !== exp.visits || got.failures !== exp.failures ||
            got.requests !== exp.requests || got.free !== exp.free) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display({"mismatch: exp st %0d idx %0d vis %0d fail %0d req %0d free %0d",
                      " / got st %0d idx %0d vis %0d fail %0d req %0d free %0d"},
                     exp.status, exp.index, exp.visits, exp.failures, exp.requests,
                     exp.free, got.status, got.index, got.visits, got.failures,
                     got.requests, got.free);
        end
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      sink_stall = pick_gap(sink_calm);
      m_axis_tready <= (sink_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic                  cmd;
    logic [SizeFieldW-1:0] size;
    plan_row_t             blank;
    bit                    more;
    blank = '0;
    for (int k = 0; k < TableDepth; k++) begin
      tbl_size[k] = '0;
      tbl_live[k] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumPlanRows; r++) begin
      if (plan[r].is_cfg) begin
        write_policy(plan[r].policy);
      end else begin
        more = (r + 1 < NumPlanRows) && !plan[r + 1].is_cfg;
        send_item(plan[r].cmd, plan[r].size, more, plan[r]);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      write_policy(phase_policy[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        random_item(cmd, size);
        send_item(cmd, size, n + 1 < PhaseItems, blank);
      end
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("%0d items under %0d policy writes, table filled to %0d entries",
             items_sent, policy_writes, fill_count);
    $display("loaded %0d, granted %0d, not granted %0d, skipped %0d, table full %0d",
             status_seen[STATUS_LOADED], status_seen[STATUS_GRANTED],
             status_seen[STATUS_NOGRANT], status_seen[STATUS_SKIPPED],
             status_seen[STATUS_FULL]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
